// ===== sv/bptc_pkg.sv =====
// Shared constants for the barometric pressure and temperature compensation block.
`timescale 1ns / 1ps

package bptc_pkg;

  // Raw conversion codes
  localparam int CODE_W   = 24;
  localparam int ADC_BITS = 24;
  localparam logic [CODE_W-1:0] ADC_MASK = {ADC_BITS{1'b1}};

  // Calibration word width and register file
  localparam int COEFF_W = 16;
  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd5;

  // Result fields
  localparam int TEMP_W  = 20;
  localparam int PRESS_W = 32;
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;

endpackage

// ===== sv/baro_pressure_temp_compensation.sv =====
// Pipelined second-order pressure and temperature compensation datapath.
// 9 register stages, Stage 1 through Stage 9; m_tvalid rises once the accepted item is in the Stage 9 output register.
// Throughput: one item per cycle while m_tready is high; each stage holds its item while the next is full.
// Multipliers are cut so that at most one sits between two registers.
// Reset (rst, synchronous) empties the pipeline and clears the calibration words to 0.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // s_tdata: pressure_code[23:0], temperature_code[47:24]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  // m_tdata: temp_centideg[19:0], pressure_tenth_mbar[51:20], zero pad[55:52]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data
);

  localparam int NSTG = 9;

  // Calibration registers
  logic [COEFF_W-1:0] sens_coeff, offset_coeff, sens_temp_coeff;
  logic [COEFF_W-1:0] offset_temp_coeff, ref_temp_code, temp_slope_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temp_code     <= '0;
      temp_slope_coeff  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENS:      sens_coeff        <= cfg_data;
        REG_OFFSET:    offset_coeff      <= cfg_data;
        REG_SENS_TEMP: sens_temp_coeff   <= cfg_data;
        REG_OFF_TEMP:  offset_temp_coeff <= cfg_data;
        REG_REF_TEMP:  ref_temp_code     <= cfg_data;
        REG_SLOPE:     temp_slope_coeff  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   ready;

  always_comb begin
    ready[NSTG] = m_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (ready[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = ready[0];
  assign m_tvalid = vld[NSTG-1];

  // Stage 1: mask codes, dT = T - (ref << 8)
  logic [CODE_W-1:0] dp_in, dtc_in;
  logic [CODE_W-1:0] s1_dp;
  logic signed [CODE_W:0] s1_dt;

  assign dp_in  = s_tdata[CODE_W-1:0] & ADC_MASK;
  assign dtc_in = s_tdata[2*CODE_W-1:CODE_W] & ADC_MASK;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      s1_dp <= dp_in;
      s1_dt <= $signed({1'b0, dtc_in}) - $signed({1'b0, ref_temp_code, 8'b0});
    end
  end

  // Stage 2: the four dT products
  logic [CODE_W-1:0]  s2_dp;
  logic signed [41:0] s2_pt, s2_po, s2_ps;
  logic signed [49:0] s2_pq;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s2_dp <= s1_dp;
      s2_pt <= s1_dt * $signed({1'b0, temp_slope_coeff});
      s2_po <= s1_dt * $signed({1'b0, offset_temp_coeff});
      s2_ps <= s1_dt * $signed({1'b0, sens_temp_coeff});
      s2_pq <= s1_dt * s1_dt;
    end
  end

  // Stage 3: first-order TEMP, OFF, SENS; low-temperature flag is the slope term's sign
  logic [CODE_W-1:0]         s3_dp;
  logic signed [18:0]        s3_x;
  logic signed [TEMP_W-1:0]  s3_temp;
  logic signed [37:0]        s3_off;
  logic signed [39:0]        s3_sens;
  logic                      s3_low;
  logic [17:0]               s3_tq;

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      s3_dp   <= s2_dp;
      s3_x    <= s2_pt[41:23];
      s3_temp <= $signed({s2_pt[41], s2_pt[41:23]}) + TEMP_BASE;
      s3_off  <= $signed({6'b0, offset_coeff, 16'b0}) + $signed({{3{s2_po[41]}}, s2_po[41:7]});
      s3_sens <= $signed({9'b0, sens_coeff, 15'b0}) + $signed({{6{s2_ps[41]}}, s2_ps[41:8]});
      s3_low  <= s2_pt[41];
      s3_tq   <= s2_pq[48:31];
    end
  end

  // Stage 4: x squared (|x| <= 2^17, so 35 bits hold it)
  logic signed [37:0]        xx_full;
  logic [CODE_W-1:0]         s4_dp;
  logic [34:0]               s4_xx;
  logic signed [TEMP_W-1:0]  s4_temp;
  logic signed [37:0]        s4_off;
  logic signed [39:0]        s4_sens;
  logic                      s4_low;
  logic [17:0]               s4_tq;

  assign xx_full = s3_x * s3_x;

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      s4_dp   <= s3_dp;
      s4_xx   <= xx_full[34:0];
      s4_temp <= s3_temp;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_low  <= s3_low;
      s4_tq   <= s3_tq;
    end
  end

  // Stage 5: 5*x*x and second-order temperature
  logic [CODE_W-1:0]         s5_dp;
  logic [36:0]               s5_sq5;
  logic signed [TEMP_W-1:0]  s5_temp;
  logic signed [37:0]        s5_off;
  logic signed [39:0]        s5_sens;
  logic                      s5_low;

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      s5_dp   <= s4_dp;
      s5_sq5  <= {2'b0, s4_xx} + {s4_xx, 2'b0};
      s5_temp <= s4_low ? s4_temp - $signed({2'b0, s4_tq}) : s4_temp;
      s5_off  <= s4_off;
      s5_sens <= s4_sens;
      s5_low  <= s4_low;
    end
  end

  // Stage 6: second-order OFF and SENS
  logic [CODE_W-1:0]         s6_dp;
  logic signed [TEMP_W-1:0]  s6_temp;
  logic signed [37:0]        s6_off;
  logic signed [39:0]        s6_sens;

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      s6_dp   <= s5_dp;
      s6_temp <= s5_temp;
      s6_off  <= s5_low ? s5_off - $signed({4'b0, s5_sq5[36:3]}) : s5_off;
      s6_sens <= s5_low ? s5_sens - $signed({4'b0, s5_sq5[36:1]}) : s5_sens;
    end
  end

  // Stage 7: D * SENS as two partial products (low 20 bits, signed high 20 bits)
  logic signed [TEMP_W-1:0]  s7_temp;
  logic signed [37:0]        s7_off;
  logic [43:0]               s7_pl;
  logic signed [44:0]        s7_ph;

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      s7_temp <= s6_temp;
      s7_off  <= s6_off;
      s7_pl   <= s6_dp * s6_sens[19:0];
      s7_ph   <= $signed({1'b0, s6_dp}) * $signed(s6_sens[39:20]);
    end
  end

  // Stage 8: recombine the product (|D*SENS| < 2^62)
  logic signed [TEMP_W-1:0]  s8_temp;
  logic signed [37:0]        s8_off;
  logic signed [63:0]        s8_prod;

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      s8_temp <= s7_temp;
      s8_off  <= s7_off;
      s8_prod <= $signed({s7_ph[43:0], 20'b0}) + $signed({20'b0, s7_pl});
    end
  end

  // Stage 9 (output register): (prod >> 21) - OFF
  logic signed [TEMP_W-1:0]  s9_temp;
  logic signed [43:0]        s9_diff;

  always_ff @(posedge clk) begin
    if (ready[8]) begin
      s9_temp <= s8_temp;
      s9_diff <= $signed({s8_prod[63], s8_prod[63:21]}) - $signed({{6{s8_off[37]}}, s8_off});
    end
  end

  // Final >> 15; both results stay inside their field ranges, so no clamp is needed
  logic [PRESS_W-1:0] press_out;

  assign press_out = {{3{s9_diff[43]}}, s9_diff[43:15]};
  assign m_tdata   = {4'b0, press_out, s9_temp};

endmodule

// ===== sv/bptc_checker.sv =====
// Port-level checks for the compensation pipeline, bound to the top level.
`timescale 1ns / 1ps

module bptc_checker
  import bptc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // A waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Free output stage means the pipeline can take an item
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with output stage free");

  // Pad bits above the pressure field stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:TEMP_W+PRESS_W] == '0)
    else $error("non-zero pad bits in result");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);
